// ===== hdl/prim_pkg.sv =====
// ----------------------------------------------------------------------------
// prim_pkg: shared constants, types and helpers of the primality tester
// Widths, screening limits, witness bases and the modular add step.
// ----------------------------------------------------------------------------
package prim_pkg;

  // width of the tested number (8..64)
  localparam int NUMBER_WIDTH = 64;
  // bit counter for one serial pass, holds NUMBER_WIDTH itself
  localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH + 1);
  // trial divisors stay below 1200
  localparam int DIV_WIDTH    = 12;
  // running square of the trial divisor, stays below 2^21
  localparam int TSQ_WIDTH    = 22;

  localparam logic [63:0] TRIAL_LIMIT    = 64'd1373653;
  localparam logic [63:0] SMALL_MR_LIMIT = 64'd9080191;

  // witness bases: small set (31, 73), large set (2, 7, 61)
  localparam logic [63:0] BASE_S0 = 64'd31;
  localparam logic [63:0] BASE_S1 = 64'd73;
  localparam logic [63:0] BASE_L0 = 64'd2;
  localparam logic [63:0] BASE_L1 = 64'd7;
  localparam logic [63:0] BASE_L2 = 64'd61;
  localparam logic [1:0]  LAST_SMALL = 2'd1;
  localparam logic [1:0]  LAST_LARGE = 2'd2;

  typedef logic [NUMBER_WIDTH-1:0] num_t;
  typedef logic [DIV_WIDTH-1:0]    div_t;
  typedef logic [CNT_WIDTH-1:0]    cnt_t;

  // (a + b) mod m for a, b < m
  function automatic num_t add_mod(num_t a, num_t b, num_t m);
    logic [NUMBER_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[NUMBER_WIDTH-1:0];
  endfunction

  // witness base by set and index
  function automatic num_t base_of(logic small_set, logic [1:0] idx);
    logic [63:0] b;
    if (small_set) begin
      b = (idx == 2'd0) ? BASE_S0 : BASE_S1;
    end else begin
      case (idx)
        2'd0:    b = BASE_L0;
        2'd1:    b = BASE_L1;
        default: b = BASE_L2;
      endcase
    end
    return b[NUMBER_WIDTH-1:0];
  endfunction

endpackage

// ===== hdl/primality_test_trial_and_miller_rabin.sv =====
// ----------------------------------------------------------------------------
// primality_test_trial_and_miller_rabin: primality tester
// Screens by 2 and 3, trial-divides small numbers by 6k-1 / 6k+1 and runs
// Miller-Rabin (bases 31, 73 or 2, 7, 61) on larger ones.
// ----------------------------------------------------------------------------
//  channel  | ports              | handshake
//  ---------+--------------------+---------------------------------------
//  request  | number             | taken when start high and busy low
//  result   | is_prime           | valid for the one cycle done is high
//
// One request at a time; busy stays high until its result is strobed.
// Time per request is set by the two serial units: a remainder pass steps
// through every dividend bit, a modular product through every multiplier
// bit with an extra add for each set bit. Trial division needs two passes
// per 6k step; Miller-Rabin needs about 1.5*NUMBER_WIDTH products per base.
// Synchronous reset returns the sequencer to idle.
// The result cannot be stalled: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module primality_test_trial_and_miller_rabin (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  prim_pkg::num_t number,
  output logic           done,
  output logic           is_prime
);
  import prim_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_SCREEN  = 12'b0000_0000_0010,
    S_MOD3    = 12'b0000_0000_0100,
    S_TRIAL   = 12'b0000_0000_1000,
    S_TDIV_HI = 12'b0000_0001_0000,
    S_TDIV_LO = 12'b0000_0010_0000,
    S_MR_INIT = 12'b0000_0100_0000,
    S_STRIP   = 12'b0000_1000_0000,
    S_POW     = 12'b0001_0000_0000,
    S_POW_M   = 12'b0010_0000_0000,
    S_POW_S   = 12'b0100_0000_0000,
    S_SQ      = 12'b1000_0000_0000
  } state_t;

  state_t state;
  num_t   n;
  logic [63:0] n_wide;
  num_t   n_minus1;
  num_t   mul_a;
  num_t   mul_b;
  logic   mul_start;
  logic   mul_done;
  num_t   mul_p;
  logic   div_start;
  div_t   div_d;
  logic   div_done;
  div_t   div_rem;
  div_t   tdiv;
  logic [TSQ_WIDTH-1:0] tsq;
  num_t   expo;
  cnt_t   rounds;
  cnt_t   iter;
  num_t   res;
  num_t   sq;
  num_t   prev;
  logic [1:0] bidx;
  logic   mr_small;

  assign n_wide   = 64'(n);
  assign n_minus1 = n - NUMBER_WIDTH'(1);
  assign busy     = (state != S_IDLE);

  prim_modmul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_a),
    .y       (mul_b),
    .m       (n),
    .done    (mul_done),
    .product (mul_p)
  );

  prim_remdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (div_d),
    .done     (div_done),
    .rem      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      is_prime  <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n     <= number;
            state <= S_SCREEN;
          end
        end
        // below 2 and even numbers, then start the check for 3
        S_SCREEN: begin
          if (n_wide < 64'd2 || (!n[0] && n_wide != 64'd2)) begin
            done <= 1'b1; is_prime <= 1'b0; state <= S_IDLE;
          end else begin
            div_d     <= DIV_WIDTH'(3);
            div_start <= 1'b1;
            state     <= S_MOD3;
          end
        end
        S_MOD3: begin
          if (div_done) begin
            if (div_rem == '0 && n_wide != 64'd3) begin
              done <= 1'b1; is_prime <= 1'b0; state <= S_IDLE;
            end else if (n_wide < TRIAL_LIMIT) begin
              tdiv  <= DIV_WIDTH'(5);
              tsq   <= TSQ_WIDTH'(25);
              state <= S_TRIAL;
            end else begin
              mr_small <= (n_wide < SMALL_MR_LIMIT);
              bidx     <= 2'd0;
              state    <= S_MR_INIT;
            end
          end
        end
        // loop while (6k-1)^2 <= n
        S_TRIAL: begin
          if (64'(tsq) <= n_wide) begin
            div_d     <= tdiv + DIV_WIDTH'(2);
            div_start <= 1'b1;
            state     <= S_TDIV_HI;
          end else begin
            done <= 1'b1; is_prime <= 1'b1; state <= S_IDLE;
          end
        end
        S_TDIV_HI: begin
          if (div_done) begin
            if (div_rem == '0) begin
              done <= 1'b1; is_prime <= 1'b0; state <= S_IDLE;
            end else begin
              div_d     <= tdiv;
              div_start <= 1'b1;
              state     <= S_TDIV_LO;
            end
          end
        end
        S_TDIV_LO: begin
          if (div_done) begin
            if (div_rem == '0) begin
              done <= 1'b1; is_prime <= 1'b0; state <= S_IDLE;
            end else begin
              // (d+6)^2 = d^2 + 12d + 36
              tsq   <= tsq + TSQ_WIDTH'({tdiv, 3'b000}) + TSQ_WIDTH'({tdiv, 2'b00})
                       + TSQ_WIDTH'(36);
              tdiv  <= tdiv + DIV_WIDTH'(6);
              state <= S_TRIAL;
            end
          end
        end
        // n-1 = d * 2^s
        S_MR_INIT: begin
          expo   <= n >> 1;
          rounds <= CNT_WIDTH'(1);
          state  <= S_STRIP;
        end
        S_STRIP: begin
          if (!expo[0] && expo != '0) begin
            expo   <= expo >> 1;
            rounds <= rounds + CNT_WIDTH'(1);
          end else begin
            res   <= NUMBER_WIDTH'(1);
            sq    <= base_of(mr_small, bidx);
            state <= S_POW;
          end
        end
        // square-and-multiply over exponent bits, LSB first
        S_POW: begin
          mul_start <= 1'b1;
          if (expo == '0) begin
            prev  <= res;
            iter  <= CNT_WIDTH'(1);
            mul_a <= res;
            mul_b <= res;
            state <= S_SQ;
          end else if (expo[0]) begin
            mul_a <= res;
            mul_b <= sq;
            state <= S_POW_M;
          end else begin
            mul_a <= sq;
            mul_b <= sq;
            state <= S_POW_S;
          end
        end
        S_POW_M: begin
          if (mul_done) begin
            res       <= mul_p;
            mul_a     <= sq;
            mul_b     <= sq;
            mul_start <= 1'b1;
            state     <= S_POW_S;
          end
        end
        S_POW_S: begin
          if (mul_done) begin
            sq    <= mul_p;
            expo  <= expo >> 1;
            state <= S_POW;
          end
        end
        // repeated squaring, looking for a non-trivial root of one
        S_SQ: begin
          if (mul_done) begin
            if (mul_p == NUMBER_WIDTH'(1) && prev != NUMBER_WIDTH'(1)
                && prev != n_minus1) begin
              done <= 1'b1; is_prime <= 1'b0; state <= S_IDLE;
            end else if (iter == rounds) begin
              if (mul_p != NUMBER_WIDTH'(1)) begin
                done <= 1'b1; is_prime <= 1'b0; state <= S_IDLE;
              end else if (bidx == (mr_small ? LAST_SMALL : LAST_LARGE)) begin
                done <= 1'b1; is_prime <= 1'b1; state <= S_IDLE;
              end else begin
                bidx  <= bidx + 2'd1;
                state <= S_MR_INIT;
              end
            end else begin
              prev      <= mul_p;
              iter      <= iter + CNT_WIDTH'(1);
              mul_a     <= mul_p;
              mul_b     <= mul_p;
              mul_start <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/prim_modmul.sv =====
// ----------------------------------------------------------------------------
// prim_modmul: bit-serial modular multiplier
// x * y mod m by double-and-add over the bits of y, MSB first; one modular
// add per cycle, the add of x only for set bits.
// ----------------------------------------------------------------------------
module prim_modmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  prim_pkg::num_t x,
  input  prim_pkg::num_t y,
  input  prim_pkg::num_t m,
  output logic           done,
  output prim_pkg::num_t product
);
  import prim_pkg::*;

  num_t acc;
  num_t xq;
  num_t yq;
  cnt_t cnt;
  logic run;
  logic phase;
  num_t addend;
  num_t sum;

  // phase 0 doubles, phase 1 adds x
  assign addend  = phase ? xq : acc;
  assign sum     = add_mod(acc, addend, m);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc   <= '0;
        xq    <= x;
        yq    <= y;
        cnt   <= CNT_WIDTH'(NUMBER_WIDTH);
        phase <= 1'b0;
        run   <= 1'b1;
      end else if (run) begin
        acc <= sum;
        if (!phase && yq[NUMBER_WIDTH-1]) begin
          phase <= 1'b1;
        end else begin
          // bit finished, move to the next one
          phase <= 1'b0;
          yq    <= yq << 1;
          cnt   <= cnt - CNT_WIDTH'(1);
          if (cnt == CNT_WIDTH'(1)) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/prim_remdiv.sv =====
// ----------------------------------------------------------------------------
// prim_remdiv: bit-serial remainder unit
// Restoring division of the number by a small divisor, one dividend bit per
// cycle, MSB first; only the remainder is kept.
// ----------------------------------------------------------------------------
module prim_remdiv (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  prim_pkg::num_t dividend,
  input  prim_pkg::div_t divisor,
  output logic           done,
  output prim_pkg::div_t rem
);
  import prim_pkg::*;

  div_t rq;
  div_t dq;
  num_t nq;
  cnt_t cnt;
  logic run;
  logic [DIV_WIDTH:0] trial;
  logic [DIV_WIDTH:0] diff;

  // shift in the next bit and subtract where it fits
  assign trial = {rq, nq[NUMBER_WIDTH-1]};
  assign diff  = trial - {1'b0, dq};
  assign rem   = rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rq  <= '0;
        dq  <= divisor;
        nq  <= dividend;
        cnt <= CNT_WIDTH'(NUMBER_WIDTH);
        run <= 1'b1;
      end else if (run) begin
        rq  <= (trial >= {1'b0, dq}) ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
        nq  <= nq << 1;
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
